[design/tts_pkg.sv]
// Shared types, widths and constants of the triangle tangent space unit.
`default_nettype none
package tts_pkg;

   // Vector component formats.
   localparam int Q14_W      = 16;
   localparam int Q14_ONE    = 16384;
   localparam int EDGE_W     = 17;
   localparam int EPS_W      = 15;
   localparam int EPS_RESET  = 1;

   // Normalizer datapath widths.
   localparam int VEC_W      = 64;
   localparam int MAG_W      = 30;
   localparam int SQ_W       = 2 * MAG_W;
   localparam int SUM_W      = SQ_W + 2;
   localparam int ROOT_W     = SUM_W / 2;
   localparam int SREM_W     = ROOT_W + 2;
   localparam int DREM_W     = ROOT_W + Q14_W - 1;
   localparam int QUO_W      = Q14_W - 1;

   // Normalizer stage map.
   localparam int UN_SHIFT_STAGES = 6;
   localparam int UN_SQ_IDX       = UN_SHIFT_STAGES + 1;
   localparam int UN_SUM_IDX      = UN_SQ_IDX + 1;
   localparam int SQRT_STEPS      = ROOT_W;
   localparam int UN_SQRT_IDX     = UN_SUM_IDX + 1;
   localparam int UN_PREP_IDX     = UN_SQRT_IDX + SQRT_STEPS;
   localparam int DIV_STEPS       = QUO_W;
   localparam int UN_DIV_IDX      = UN_PREP_IDX + 1;
   localparam int UN_OUT_IDX      = UN_DIV_IDX + DIV_STEPS;
   localparam int UN_STAGES       = UN_OUT_IDX + 1;

   // Tangent datapath widths.
   localparam int PROD_W     = 2 * Q14_W;
   localparam int DIFF_W     = PROD_W + 1;
   localparam int TAN_W      = 31;
   localparam int TAN_ONE    = 1 << 28;
   localparam int NT_W       = Q14_W + TAN_W;
   localparam int NDT_W      = NT_W + 2;
   localparam int NDT_LO_W   = 23;
   localparam int NDT_HI_W   = NDT_W - NDT_LO_W;
   localparam int PL_W       = Q14_W + NDT_LO_W + 1;
   localparam int PH_W       = Q14_W + NDT_HI_W;
   localparam int GS_SHIFT   = 28;
   localparam int BT_W       = PROD_W + 1;
   localparam int HP_W       = 64;
   localparam int HDOT_W     = HP_W + 2;

   typedef logic signed [Q14_W-1:0] q14_type;

   // Sideband word that rides along with the tangent through the second normalizer.
   typedef struct packed {
      logic [1:0]                pad;
      logic                      degen;
      logic [2:0][TAN_W-1:0]     bin;
      logic [3*Q14_W-1:0]        nrm;
   } gside_type;

   localparam int SIDE_W = $bits(gside_type);

   // Per-stage bookkeeping of the normalizer.
   typedef struct packed {
      logic              zero;
      logic [2:0]        neg;
      logic [SIDE_W-1:0] side;
   } un_meta_type;

endpackage
`default_nettype wire

[design/tts_unitize.sv]
// Pipelined three-component vector normalizer with Q1.14 results.
`default_nettype none
module tts_unitize import tts_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire logic                    in_valid,
   input  wire logic signed [VEC_W-1:0] in_comp [3],
   input  wire logic [SIDE_W-1:0]       in_side,
   output logic                         out_valid,
   output q14_type                      out_comp [3],
   output logic [SIDE_W-1:0]            out_side
);

   logic              vld_ff  [UN_STAGES];
   un_meta_type       meta_ff [UN_STAGES];

   logic [VEC_W-1:0]  mag_ff  [UN_SHIFT_STAGES+1][3];
   logic [VEC_W-1:0]  orw_ff  [UN_SHIFT_STAGES+1];
   logic [VEC_W-1:0]  mag_in  [3];
   logic [VEC_W-1:0]  orw_in;
   logic [2:0]        neg_in;

   logic [MAG_W-1:0]  m_sq_ff  [3];
   logic [SQ_W-1:0]   sq_ff    [3];
   logic [MAG_W-1:0]  m_sum_ff [3];
   logic [SUM_W-1:0]  sum_ff;

   logic [SUM_W-1:0]  sx_ff    [SQRT_STEPS];
   logic [SREM_W-1:0] srem_ff  [SQRT_STEPS];
   logic [ROOT_W-1:0] sroot_ff [SQRT_STEPS];
   logic [MAG_W-1:0]  sm_ff    [SQRT_STEPS][3];

   logic [DREM_W-1:0] dn_ff [3];
   logic [ROOT_W-1:0] dlen_ff;

   logic [DREM_W-1:0] drem_ff [DIV_STEPS][3];
   logic [QUO_W-1:0]  dq_ff   [DIV_STEPS][3];
   logic [ROOT_W-1:0] dl_ff   [DIV_STEPS];

   q14_type           out_ff [3];

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < UN_STAGES; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (advance) begin
         vld_ff[0] <= in_valid;
         for (int s = 1; s < UN_STAGES; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   // Magnitudes, signs and the OR of the magnitudes, which shares the largest one's top bit.
   always_comb begin
      orw_in = '0;
      for (int i = 0; i < 3; i++) begin
         neg_in[i] = in_comp[i][VEC_W-1];
         mag_in[i] = neg_in[i] ? VEC_W'(-in_comp[i]) : VEC_W'(in_comp[i]);
         orw_in    = orw_in | mag_in[i];
      end
   end

   // Sideband and flags; the zero flag is set once the alignment is done.
   always_ff @(posedge clock) begin
      if (advance) begin
         meta_ff[0] <= '{zero: 1'b0, neg: neg_in, side: in_side};
         for (int s = 1; s < UN_STAGES; s++) begin
            if (s == UN_SQ_IDX) begin
               meta_ff[s] <= '{zero: (orw_ff[UN_SHIFT_STAGES] == '0),
                               neg: meta_ff[s-1].neg, side: meta_ff[s-1].side};
            end else begin
               meta_ff[s] <= meta_ff[s-1];
            end
         end
         mag_ff[0] <= mag_in;
         orw_ff[0] <= orw_in;
      end
   end

   // Alignment: shift left so that the largest magnitude's top bit lands in the top bit.
   for (genvar s = 1; s <= UN_SHIFT_STAGES; s++) begin : g_align
      localparam int AMT = 1 << (UN_SHIFT_STAGES - s);
      logic hit;
      assign hit = (orw_ff[s-1][VEC_W-1 -: AMT] == '0);
      always_ff @(posedge clock) begin
         if (advance) begin
            orw_ff[s] <= hit ? (orw_ff[s-1] << AMT) : orw_ff[s-1];
            for (int i = 0; i < 3; i++) begin
               mag_ff[s][i] <= hit ? (mag_ff[s-1][i] << AMT) : mag_ff[s-1][i];
            end
         end
      end
   end

   // Squares of the aligned magnitudes, then their sum.
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            m_sq_ff[i] <= mag_ff[UN_SHIFT_STAGES][i][VEC_W-1 -: MAG_W];
            sq_ff[i]   <= SQ_W'(mag_ff[UN_SHIFT_STAGES][i][VEC_W-1 -: MAG_W])
                        * SQ_W'(mag_ff[UN_SHIFT_STAGES][i][VEC_W-1 -: MAG_W]);
         end
         sum_ff   <= SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
         m_sum_ff <= m_sq_ff;
      end
   end

   // Integer square root, one result bit per stage.
   for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_sqrt
      logic [SUM_W-1:0]  px;
      logic [SREM_W-1:0] prem;
      logic [ROOT_W-1:0] proot;
      logic [MAG_W-1:0]  pm [3];
      logic [SREM_W+1:0] raw;
      logic [SREM_W+1:0] trial;
      logic              ge;
      if (s == 0) begin : g_first
         always_comb begin
            px    = sum_ff;
            prem  = '0;
            proot = '0;
            pm    = m_sum_ff;
         end
      end else begin : g_next
         always_comb begin
            px    = sx_ff[s-1];
            prem  = srem_ff[s-1];
            proot = sroot_ff[s-1];
            pm    = sm_ff[s-1];
         end
      end
      always_comb begin
         raw   = {prem, px[SUM_W-1 -: 2]};
         trial = {2'b00, proot, 2'b01};
         ge    = (raw >= trial);
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            sx_ff[s]    <= px << 2;
            srem_ff[s]  <= ge ? SREM_W'(raw - trial) : SREM_W'(raw);
            sroot_ff[s] <= {proot[ROOT_W-2:0], ge};
            sm_ff[s]    <= pm;
         end
      end
   end

   // Rounded dividend m * 2^14 + floor(L / 2).
   always_ff @(posedge clock) begin
      if (advance) begin
         dlen_ff <= sroot_ff[SQRT_STEPS-1];
         for (int i = 0; i < 3; i++) begin
            dn_ff[i] <= DREM_W'({sm_ff[SQRT_STEPS-1][i], 14'b0})
                      + DREM_W'(sroot_ff[SQRT_STEPS-1] >> 1);
         end
      end
   end

   // Restoring division by the length, one quotient bit per stage.
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      localparam int BITPOS = DIV_STEPS - 1 - j;
      logic [DREM_W-1:0] prem [3];
      logic [QUO_W-1:0]  pq   [3];
      logic [ROOT_W-1:0] plen;
      logic [DREM_W-1:0] dv;
      if (j == 0) begin : g_first
         always_comb begin
            prem = dn_ff;
            plen = dlen_ff;
            for (int i = 0; i < 3; i++) begin
               pq[i] = '0;
            end
         end
      end else begin : g_next
         always_comb begin
            prem = drem_ff[j-1];
            plen = dl_ff[j-1];
            pq   = dq_ff[j-1];
         end
      end
      assign dv = DREM_W'(plen) << BITPOS;
      always_ff @(posedge clock) begin
         if (advance) begin
            dl_ff[j] <= plen;
            for (int i = 0; i < 3; i++) begin
               if (prem[i] >= dv) begin
                  drem_ff[j][i] <= prem[i] - dv;
                  dq_ff[j][i]   <= {pq[i][QUO_W-2:0], 1'b1};
               end else begin
                  drem_ff[j][i] <= prem[i];
                  dq_ff[j][i]   <= {pq[i][QUO_W-2:0], 1'b0};
               end
            end
         end
      end
   end

   // Saturate, apply signs and force zero vectors to zero.
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            logic [QUO_W-1:0] qs;
            qs = (dq_ff[DIV_STEPS-1][i] > QUO_W'(Q14_ONE)) ? QUO_W'(Q14_ONE)
                                                             : dq_ff[DIV_STEPS-1][i];
            if (meta_ff[UN_OUT_IDX-1].zero) begin
               out_ff[i] <= '0;
            end else if (meta_ff[UN_OUT_IDX-1].neg[i]) begin
               out_ff[i] <= -Q14_W'(qs);
            end else begin
               out_ff[i] <= Q14_W'(qs);
            end
         end
      end
   end

   assign out_valid = vld_ff[UN_STAGES-1];
   assign out_comp  = out_ff;
   assign out_side  = meta_ff[UN_STAGES-1].side;

endmodule
`default_nettype wire

[design/triangle_tangent_space_unit.sv]
// Top level of the triangle tangent space unit: edges, solve, Gram-Schmidt and handedness.
// Throughput: one triangle per cycle while the pipeline advances; the normalizers in series set most of the depth.
// The whole pipeline advances while the response register is empty or being taken.
// Reset (synchronous, active high) clears all valid bits and sets det_epsilon to 1.
// Payload registers are not reset.
`default_nettype none
module triangle_tangent_space_unit import tts_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [47:0]       req_vertex_a,
   input  wire logic [47:0]       req_vertex_b,
   input  wire logic [47:0]       req_vertex_c,
   input  wire logic [31:0]       req_texcoord_a,
   input  wire logic [31:0]       req_texcoord_b,
   input  wire logic [31:0]       req_texcoord_c,
   input  wire logic [47:0]       req_face_normal,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic signed [15:0]     rsp_tangent_x,
   output logic signed [15:0]     rsp_tangent_y,
   output logic signed [15:0]     rsp_tangent_z,
   output logic                   rsp_handedness_negative,
   output logic                   rsp_degenerate,
   input  wire logic              csr_write_enable,
   input  wire logic [EPS_W-1:0]  csr_write_data
);

   logic                    advance;
   logic [EPS_W-1:0]        eps_ff;

   // Edge stage.
   logic                    t0_vld_ff;
   logic signed [EDGE_W-1:0] t0_d1_ff [3];
   logic signed [EDGE_W-1:0] t0_d2_ff [3];
   logic signed [EDGE_W-1:0] t0_t1_ff [2];
   logic signed [EDGE_W-1:0] t0_t2_ff [2];
   logic [3*Q14_W-1:0]      t0_nrm_ff;
   logic signed [EDGE_W-1:0] d1_in [3];
   logic signed [EDGE_W-1:0] d2_in [3];
   logic signed [EDGE_W-1:0] t1_in [2];
   logic signed [EDGE_W-1:0] t2_in [2];

   // First normalizer group.
   logic signed [VEC_W-1:0] u_e1_in [3];
   logic signed [VEC_W-1:0] u_e2_in [3];
   logic signed [VEC_W-1:0] u_t1_in [3];
   logic signed [VEC_W-1:0] u_t2_in [3];
   logic [SIDE_W-1:0]       u1_side_in;
   logic                    u1_vld;
   q14_type                 e1 [3];
   q14_type                 e2 [3];
   q14_type                 t1 [3];
   q14_type                 t2 [3];
   logic [SIDE_W-1:0]       u1_side;

   // Solve stages.
   logic                    p1_vld_ff, p2_vld_ff, p3_vld_ff, p4_vld_ff, p5_vld_ff;
   logic                    p6_vld_ff, p7_vld_ff, p8_vld_ff, p9_vld_ff, p10_vld_ff;
   logic [3*Q14_W-1:0]      p1_nrm_ff, p2_nrm_ff, p3_nrm_ff, p4_nrm_ff, p5_nrm_ff, p6_nrm_ff;
   logic signed [PROD_W-1:0] p1_dta_ff, p1_dtb_ff;
   logic signed [PROD_W-1:0] p1_ta_ff [3];
   logic signed [PROD_W-1:0] p1_tb_ff [3];
   logic signed [PROD_W-1:0] p1_ba_ff [3];
   logic signed [PROD_W-1:0] p1_bb_ff [3];
   logic signed [DIFF_W-1:0] p2_det_ff;
   logic signed [DIFF_W-1:0] p2_tan_ff [3];
   logic signed [DIFF_W-1:0] p2_bin_ff [3];
   logic                    det_neg;
   logic [DIFF_W-1:0]       adet;
   logic                    degen_in;
   logic signed [TAN_W-1:0] tan_in [3];
   logic signed [TAN_W-1:0] bin_in [3];
   logic signed [TAN_W-1:0] p3_tan_ff [3], p4_tan_ff [3], p5_tan_ff [3], p6_tan_ff [3];
   logic signed [TAN_W-1:0] p3_bin_ff [3], p4_bin_ff [3], p5_bin_ff [3], p6_bin_ff [3];
   logic                    p3_degen_ff, p4_degen_ff, p5_degen_ff, p6_degen_ff;
   logic signed [NT_W-1:0]  p4_nt_ff [3];
   logic signed [NDT_W-1:0] p5_ndt_ff;
   logic signed [PL_W-1:0]  p6_pl_ff [3];
   logic signed [PH_W-1:0]  p6_ph_ff [3];
   logic signed [VEC_W-1:0] p7_g_ff [3];
   gside_type               p7_side_ff;

   // Second normalizer and handedness stages.
   logic                    u2_vld;
   q14_type                 tn [3];
   logic [SIDE_W-1:0]       u2_side;
   gside_type               u2_gs;
   q14_type                 u2_nrm [3];
   q14_type                 p8_tn_ff [3], p9_tn_ff [3], p10_tn_ff [3];
   logic signed [TAN_W-1:0] p8_bin_ff [3], p9_bin_ff [3];
   logic                    p8_degen_ff, p9_degen_ff, p10_degen_ff;
   logic signed [PROD_W-1:0] p8_cp_ff [6];
   logic signed [BT_W-1:0]  p9_bt_ff [3];
   logic signed [HP_W-1:0]  p10_hp_ff [3];
   logic signed [HDOT_W-1:0] hdot;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // Threshold register.
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_W'(EPS_RESET);
      end else if (csr_write_enable) begin
         eps_ff <= csr_write_data;
      end
   end

   // Valid bits of the local stages and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         t0_vld_ff  <= 1'b0;
         p1_vld_ff  <= 1'b0;
         p2_vld_ff  <= 1'b0;
         p3_vld_ff  <= 1'b0;
         p4_vld_ff  <= 1'b0;
         p5_vld_ff  <= 1'b0;
         p6_vld_ff  <= 1'b0;
         p7_vld_ff  <= 1'b0;
         p8_vld_ff  <= 1'b0;
         p9_vld_ff  <= 1'b0;
         p10_vld_ff <= 1'b0;
         rsp_valid  <= 1'b0;
      end else if (advance) begin
         t0_vld_ff  <= req_valid;
         p1_vld_ff  <= u1_vld;
         p2_vld_ff  <= p1_vld_ff;
         p3_vld_ff  <= p2_vld_ff;
         p4_vld_ff  <= p3_vld_ff;
         p5_vld_ff  <= p4_vld_ff;
         p6_vld_ff  <= p5_vld_ff;
         p7_vld_ff  <= p6_vld_ff;
         p8_vld_ff  <= u2_vld;
         p9_vld_ff  <= p8_vld_ff;
         p10_vld_ff <= p9_vld_ff;
         rsp_valid  <= p10_vld_ff;
      end
   end

   // Position and texture edges, exact.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d1_in[i] = EDGE_W'($signed(req_vertex_b[16*i +: 16]))
                  - EDGE_W'($signed(req_vertex_a[16*i +: 16]));
         d2_in[i] = EDGE_W'($signed(req_vertex_c[16*i +: 16]))
                  - EDGE_W'($signed(req_vertex_a[16*i +: 16]));
      end
      for (int i = 0; i < 2; i++) begin
         t1_in[i] = EDGE_W'($signed(req_texcoord_b[16*i +: 16]))
                  - EDGE_W'($signed(req_texcoord_a[16*i +: 16]));
         t2_in[i] = EDGE_W'($signed(req_texcoord_c[16*i +: 16]))
                  - EDGE_W'($signed(req_texcoord_a[16*i +: 16]));
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         t0_d1_ff  <= d1_in;
         t0_d2_ff  <= d2_in;
         t0_t1_ff  <= t1_in;
         t0_t2_ff  <= t2_in;
         t0_nrm_ff <= req_face_normal;
      end
   end

   // Inputs of the edge normalizers e1, e2, t1 and t2; the normal rides with the first one.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         u_e1_in[i] = VEC_W'(t0_d1_ff[i]);
         u_e2_in[i] = VEC_W'(t0_d2_ff[i]);
      end
      for (int i = 0; i < 2; i++) begin
         u_t1_in[i] = VEC_W'(t0_t1_ff[i]);
         u_t2_in[i] = VEC_W'(t0_t2_ff[i]);
      end
      u_t1_in[2] = '0;
      u_t2_in[2] = '0;
      u1_side_in = SIDE_W'(t0_nrm_ff);
   end

   tts_unitize u_norm_e1 (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (t0_vld_ff),
      .in_comp   (u_e1_in),
      .in_side   (u1_side_in),
      .out_valid (u1_vld),
      .out_comp  (e1),
      .out_side  (u1_side)
   );

   tts_unitize u_norm_e2 (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (t0_vld_ff),
      .in_comp   (u_e2_in),
      .in_side   ('0),
      .out_valid (),
      .out_comp  (e2),
      .out_side  ()
   );

   tts_unitize u_norm_t1 (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (t0_vld_ff),
      .in_comp   (u_t1_in),
      .in_side   ('0),
      .out_valid (),
      .out_comp  (t1),
      .out_side  ()
   );

   tts_unitize u_norm_t2 (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (t0_vld_ff),
      .in_comp   (u_t2_in),
      .in_side   ('0),
      .out_valid (),
      .out_comp  (t2),
      .out_side  ()
   );

   // Products for the determinant, tangent and binormal.
   always_ff @(posedge clock) begin
      if (advance) begin
         p1_nrm_ff <= u1_side[3*Q14_W-1:0];
         p1_dta_ff <= PROD_W'(t1[0]) * PROD_W'(t2[1]);
         p1_dtb_ff <= PROD_W'(t2[0]) * PROD_W'(t1[1]);
         for (int i = 0; i < 3; i++) begin
            p1_ta_ff[i] <= PROD_W'(t2[1]) * PROD_W'(e1[i]);
            p1_tb_ff[i] <= PROD_W'(t1[1]) * PROD_W'(e2[i]);
            p1_ba_ff[i] <= PROD_W'(t1[0]) * PROD_W'(e2[i]);
            p1_bb_ff[i] <= PROD_W'(t2[0]) * PROD_W'(e1[i]);
         end
      end
   end

   // Differences.
   always_ff @(posedge clock) begin
      if (advance) begin
         p2_nrm_ff <= p1_nrm_ff;
         p2_det_ff <= DIFF_W'(p1_dta_ff) - DIFF_W'(p1_dtb_ff);
         for (int i = 0; i < 3; i++) begin
            p2_tan_ff[i] <= DIFF_W'(p1_ta_ff[i]) - DIFF_W'(p1_tb_ff[i]);
            p2_bin_ff[i] <= DIFF_W'(p1_ba_ff[i]) - DIFF_W'(p1_bb_ff[i]);
         end
      end
   end

   // Degenerate test and selection; a negative determinant flips both vectors.
   always_comb begin
      det_neg  = p2_det_ff[DIFF_W-1];
      adet     = det_neg ? DIFF_W'(-p2_det_ff) : DIFF_W'(p2_det_ff);
      degen_in = (adet <= DIFF_W'({eps_ff, 14'b0}));
      for (int i = 0; i < 3; i++) begin
         if (degen_in) begin
            tan_in[i] = (i == 0) ? TAN_W'(TAN_ONE) : '0;
            bin_in[i] = (i == 1) ? TAN_W'(TAN_ONE) : '0;
         end else if (det_neg) begin
            tan_in[i] = TAN_W'(-p2_tan_ff[i]);
            bin_in[i] = TAN_W'(-p2_bin_ff[i]);
         end else begin
            tan_in[i] = TAN_W'(p2_tan_ff[i]);
            bin_in[i] = TAN_W'(p2_bin_ff[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p3_nrm_ff   <= p2_nrm_ff;
         p3_tan_ff   <= tan_in;
         p3_bin_ff   <= bin_in;
         p3_degen_ff <= degen_in;
      end
   end

   // Normal times tangent, then the dot product.
   always_ff @(posedge clock) begin
      if (advance) begin
         p4_nrm_ff   <= p3_nrm_ff;
         p4_tan_ff   <= p3_tan_ff;
         p4_bin_ff   <= p3_bin_ff;
         p4_degen_ff <= p3_degen_ff;
         for (int i = 0; i < 3; i++) begin
            p4_nt_ff[i] <= NT_W'($signed(p3_nrm_ff[16*i +: 16])) * NT_W'(p3_tan_ff[i]);
         end
         p5_nrm_ff   <= p4_nrm_ff;
         p5_tan_ff   <= p4_tan_ff;
         p5_bin_ff   <= p4_bin_ff;
         p5_degen_ff <= p4_degen_ff;
         p5_ndt_ff   <= NDT_W'(p4_nt_ff[0]) + NDT_W'(p4_nt_ff[1]) + NDT_W'(p4_nt_ff[2]);
      end
   end

   // Normal times the dot product, split into a low and a high partial product.
   always_ff @(posedge clock) begin
      if (advance) begin
         p6_nrm_ff   <= p5_nrm_ff;
         p6_tan_ff   <= p5_tan_ff;
         p6_bin_ff   <= p5_bin_ff;
         p6_degen_ff <= p5_degen_ff;
         for (int i = 0; i < 3; i++) begin
            p6_pl_ff[i] <= PL_W'($signed(p5_nrm_ff[16*i +: 16]))
                         * PL_W'($signed({1'b0, p5_ndt_ff[NDT_LO_W-1:0]}));
            p6_ph_ff[i] <= PH_W'($signed(p5_nrm_ff[16*i +: 16]))
                         * PH_W'($signed(p5_ndt_ff[NDT_W-1:NDT_LO_W]));
         end
      end
   end

   // Gram-Schmidt: G = T * 2^28 - N * (N.T), exact.
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            p7_g_ff[i] <= (VEC_W'(p6_tan_ff[i]) <<< GS_SHIFT)
                        - ((VEC_W'(p6_ph_ff[i]) <<< NDT_LO_W) + VEC_W'(p6_pl_ff[i]));
            p7_side_ff.bin[i] <= p6_bin_ff[i];
         end
         p7_side_ff.pad   <= '0;
         p7_side_ff.degen <= p6_degen_ff;
         p7_side_ff.nrm   <= p6_nrm_ff;
      end
   end

   tts_unitize u_norm_gs (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (p7_vld_ff),
      .in_comp   (p7_g_ff),
      .in_side   (p7_side_ff),
      .out_valid (u2_vld),
      .out_comp  (tn),
      .out_side  (u2_side)
   );

   always_comb begin
      u2_gs = gside_type'(u2_side);
      for (int i = 0; i < 3; i++) begin
         u2_nrm[i] = $signed(u2_gs.nrm[16*i +: 16]);
      end
   end

   // Cross product of normal and tangent: products, then differences.
   always_ff @(posedge clock) begin
      if (advance) begin
         p8_tn_ff    <= tn;
         p8_degen_ff <= u2_gs.degen;
         for (int i = 0; i < 3; i++) begin
            p8_bin_ff[i] <= $signed(u2_gs.bin[i]);
         end
         p8_cp_ff[0] <= PROD_W'(u2_nrm[1]) * PROD_W'(tn[2]);
         p8_cp_ff[1] <= PROD_W'(u2_nrm[2]) * PROD_W'(tn[1]);
         p8_cp_ff[2] <= PROD_W'(u2_nrm[2]) * PROD_W'(tn[0]);
         p8_cp_ff[3] <= PROD_W'(u2_nrm[0]) * PROD_W'(tn[2]);
         p8_cp_ff[4] <= PROD_W'(u2_nrm[0]) * PROD_W'(tn[1]);
         p8_cp_ff[5] <= PROD_W'(u2_nrm[1]) * PROD_W'(tn[0]);
         p9_tn_ff    <= p8_tn_ff;
         p9_degen_ff <= p8_degen_ff;
         p9_bin_ff   <= p8_bin_ff;
         for (int i = 0; i < 3; i++) begin
            p9_bt_ff[i] <= BT_W'(p8_cp_ff[2*i]) - BT_W'(p8_cp_ff[2*i+1]);
         end
      end
   end

   // Handedness products.
   always_ff @(posedge clock) begin
      if (advance) begin
         p10_tn_ff    <= p9_tn_ff;
         p10_degen_ff <= p9_degen_ff;
         for (int i = 0; i < 3; i++) begin
            p10_hp_ff[i] <= HP_W'(p9_bt_ff[i]) * HP_W'(p9_bin_ff[i]);
         end
      end
   end

   // Response register; handedness is negative unless the dot product is below zero.
   assign hdot = HDOT_W'(p10_hp_ff[0]) + HDOT_W'(p10_hp_ff[1]) + HDOT_W'(p10_hp_ff[2]);

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_tangent_x           <= p10_tn_ff[0];
         rsp_tangent_y           <= p10_tn_ff[1];
         rsp_tangent_z           <= p10_tn_ff[2];
         rsp_handedness_negative <= !hdot[HDOT_W-1];
         rsp_degenerate          <= p10_degen_ff;
      end
   end

endmodule
`default_nettype wire
